// ===== hdl/image_conv_3x3_zero_padded_macros.svh =====
// assertion macros for the checker file of the image correlation block
`ifndef IMAGE_CONV_3X3_ZERO_PADDED_MACROS_SVH
`define IMAGE_CONV_3X3_ZERO_PADDED_MACROS_SVH

// same-cycle implication, switched off while reset is low
`define IMCONV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, switched off while reset is low
`define IMCONV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication that also holds across reset
`define IMCONV_ASSERT_RAW(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/imconv_pkg.sv =====
// shared widths, register indexes and reset values of the image correlation block
package imconv_pkg;

    // field widths
    localparam int PIX_W      = 16;
    localparam int SUM_W      = 35;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 36;
    localparam int ROW_W      = 13;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOT   = 3'd4;

    // reset values: 1024 x 1 frame, kernel is the identity
    localparam logic [IMG_W_W-1:0]    RST_IMG_WIDTH  = 11'd1024;
    localparam logic [IMG_H_W-1:0]    RST_IMG_HEIGHT = 13'd1;
    localparam logic [CFG_DATA_W-1:0] RST_COEF_MID   = 48'h0000_0100_0000;
    localparam logic [IMG_H_W-1:0]    HEIGHT_LIMIT   = 13'd4096;

    // input command codes
    localparam logic CMD_PIXEL = 1'b0;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [2:0]       t_mask;

endpackage

// ===== hdl/imconv_ram.sv =====
// generic single-write, single-read RAM with registered read data
module imconv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port, read returns the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/image_conv_3x3_zero_padded.sv =====
// 3x3 zero-padded image correlation over a raster pixel stream
//
// Pixels enter on s_axis in raster order, one word each; s_axis_tuser is the
// command (0 pixel, 1 flush word). A result leaves on m_axis for frame
// position p together with the input word p+W+1, so W+1 flush words after a
// frame of W*H pixels drain it; m_axis_tlast marks the final result of a frame.
// Geometry and the three kernel rows (Q8.8, left coefficient in the low bits)
// are written through i_cfg_we/i_cfg_addr/i_cfg_data, by the user only while
// the block is idle (not enforced); writing width or height restarts the frame.
// Throughput: one word per clock while m_axis does not stall. A result reaches
// m_axis through the line store read stage, the window registers and one
// multiply-and-sum stage into the output register.
// The two previous rows sit in one line RAM of ROW_CAP entries read and
// written once per word; a word read at the column just written is forwarded.
// Reset (synchronous, active low) clears the counters, the window and all
// valid flags, and loads a 1024 x 1 frame with the identity kernel; the line
// RAM is not cleared, its stale entries only feed masked neighbours.
// When m_axis stalls, the output register holds and words are still taken
// until stage 2 holds a result word and stage 1 a word; then s_axis_tready drops.
module image_conv_3x3_zero_padded #(
    parameter int ROW_CAP = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pixel_value
    input  logic        s_axis_tuser,   // [0] command
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [34:0] filtered_value, [39:35] zero
    output logic        m_axis_tlast,   // last_of_frame
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [47:0] i_cfg_data
);

    localparam int COL_W = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1;
    localparam int WID_W = $clog2(ROW_CAP + 1);
    localparam int CMP_W = ((WID_W > imconv_pkg::IMG_W_W) ? WID_W : imconv_pkg::IMG_W_W) + 1;
    localparam int PR_W  = imconv_pkg::ROW_W + 2;
    localparam int PAD_W = imconv_pkg::M_TDATA_W - imconv_pkg::SUM_W;
    localparam int RAM_W = 2 * imconv_pkg::PIX_W;

    // configuration registers
    logic [imconv_pkg::IMG_W_W-1:0]    r_img_width;
    logic [imconv_pkg::IMG_H_W-1:0]    r_img_height;
    logic [imconv_pkg::CFG_DATA_W-1:0] r_coef_top;
    logic [imconv_pkg::CFG_DATA_W-1:0] r_coef_mid;
    logic [imconv_pkg::CFG_DATA_W-1:0] r_coef_bot;

    // position counters
    logic [COL_W-1:0]            r_col;
    logic [imconv_pkg::ROW_W-1:0] r_row;
    logic [COL_W-1:0]            n_col;
    logic [imconv_pkg::ROW_W-1:0] n_row;

    // geometry and position decode
    logic [CMP_W-1:0]              width_used;
    logic [CMP_W-1:0]              width_m1;
    logic [imconv_pkg::IMG_H_W-1:0] height_used;
    logic [COL_W-1:0]              col_eff;
    logic [CMP_W-1:0]              col_next;
    logic [COL_W-1:0]              pc;
    logic signed [PR_W-1:0]        pr;
    logic signed [PR_W-1:0]        h_s;
    imconv_pkg::t_pix              cur;
    logic                          has_res;
    logic                          is_last;
    imconv_pkg::t_mask             rmask;
    imconv_pkg::t_mask             cmask;

    // handshake
    logic in_accept;
    logic out_ready;
    logic s1_fire;
    logic s1_free;
    logic s2_fire;
    logic s2_free;

    // stage 1: line RAM read
    logic                 r_s1_valid;
    logic [COL_W-1:0]     r_s1_col;
    imconv_pkg::t_pix     r_s1_cur;
    logic                 r_s1_res;
    logic                 r_s1_last;
    imconv_pkg::t_mask    r_s1_rmask;
    imconv_pkg::t_mask    r_s1_cmask;
    logic                 r_s1_fwd;
    logic [RAM_W-1:0]     r_s1_fwd_data;
    logic [RAM_W-1:0]     ram_rdata;
    logic [RAM_W-1:0]     pair;
    imconv_pkg::t_pix     above2;
    imconv_pkg::t_pix     above1;

    // stage 2: window and multiply-and-sum
    logic [imconv_pkg::PIX_W-1:0] r_win [3][3];
    logic                 r_s2_valid;
    logic                 r_s2_last;
    imconv_pkg::t_mask    r_s2_rmask;
    imconv_pkg::t_mask    r_s2_cmask;
    logic [imconv_pkg::CFG_DATA_W-1:0] coef_rows [3];
    logic signed [imconv_pkg::ACC_W-1:0] acc;

    // output register
    logic                          r_out_valid;
    logic [imconv_pkg::SUM_W-1:0]  r_out_data;
    logic                          r_out_last;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= imconv_pkg::RST_IMG_WIDTH;
            r_img_height <= imconv_pkg::RST_IMG_HEIGHT;
            r_coef_top   <= '0;
            r_coef_mid   <= imconv_pkg::RST_COEF_MID;
            r_coef_bot   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                imconv_pkg::CFG_IMG_WIDTH:  r_img_width  <= i_cfg_data[imconv_pkg::IMG_W_W-1:0];
                imconv_pkg::CFG_IMG_HEIGHT: r_img_height <= i_cfg_data[imconv_pkg::IMG_H_W-1:0];
                imconv_pkg::CFG_COEF_TOP:   r_coef_top   <= i_cfg_data;
                imconv_pkg::CFG_COEF_MID:   r_coef_mid   <= i_cfg_data;
                imconv_pkg::CFG_COEF_BOT:   r_coef_bot   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp geometry to the supported range
    always_comb begin
        if (r_img_width == '0) begin
            width_used = CMP_W'(1);
        end else if (CMP_W'(r_img_width) > CMP_W'(ROW_CAP)) begin
            width_used = CMP_W'(ROW_CAP);
        end else begin
            width_used = CMP_W'(r_img_width);
        end
        if (r_img_height == '0) begin
            height_used = imconv_pkg::IMG_H_W'(1);
        end else if (r_img_height > imconv_pkg::HEIGHT_LIMIT) begin
            height_used = imconv_pkg::HEIGHT_LIMIT;
        end else begin
            height_used = r_img_height;
        end
        width_m1 = width_used - CMP_W'(1);
        h_s      = $signed({2'b00, height_used});
    end

    // window centre position, border masks and counter advance
    always_comb begin
        col_eff = (CMP_W'(r_col) >= width_used) ? '0 : r_col;
        cur = ((s_axis_tuser == imconv_pkg::CMD_PIXEL) && (r_row < height_used))
              ? s_axis_tdata : '0;
        if (col_eff != '0) begin
            pr = $signed({2'b00, r_row}) - PR_W'(1);
            pc = col_eff - COL_W'(1);
        end else begin
            pr = $signed({2'b00, r_row}) - PR_W'(2);
            pc = width_m1[COL_W-1:0];
        end
        has_res  = (pr >= 0) && (pr < h_s);
        rmask[0] = (pr >= 1);
        rmask[1] = 1'b1;
        rmask[2] = (pr < (h_s - PR_W'(1)));
        cmask[0] = (pc != '0);
        cmask[1] = 1'b1;
        cmask[2] = (CMP_W'(pc) < width_m1);
        is_last  = (pr == (h_s - PR_W'(1))) && (CMP_W'(pc) == width_m1);

        col_next = CMP_W'(col_eff) + CMP_W'(1);
        if (has_res && is_last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_next >= width_used) begin
            n_col = '0;
            n_row = r_row + imconv_pkg::ROW_W'(1);
        end else begin
            n_col = col_next[COL_W-1:0];
            n_row = r_row;
        end
    end

    // position counters, restarted by a geometry write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we && ((i_cfg_addr == imconv_pkg::CFG_IMG_WIDTH) ||
                                  (i_cfg_addr == imconv_pkg::CFG_IMG_HEIGHT))) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage handshakes
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s2_fire       = r_s2_valid && out_ready;
    assign s2_free       = !r_s2_valid || out_ready;
    assign s1_fire       = r_s1_valid && s2_free;
    assign s1_free       = !r_s1_valid || s1_fire;
    assign s_axis_tready = s1_free;
    assign in_accept     = s_axis_tvalid && s1_free;

    // line RAM: upper half row-2, lower half row-1
    imconv_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ROW_CAP)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata ({above1, r_s1_cur}),
        .i_re    (in_accept),
        .i_raddr (col_eff),
        .o_rdata (ram_rdata)
    );

    // forward the pair being written when the same column is read
    assign pair   = r_s1_fwd ? r_s1_fwd_data : ram_rdata;
    assign above2 = pair[RAM_W-1:imconv_pkg::PIX_W];
    assign above1 = pair[imconv_pkg::PIX_W-1:0];

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
        if (in_accept) begin
            r_s1_col      <= col_eff;
            r_s1_cur      <= cur;
            r_s1_res      <= has_res;
            r_s1_last     <= is_last;
            r_s1_rmask    <= rmask;
            r_s1_cmask    <= cmask;
            r_s1_fwd      <= s1_fire && (col_eff == r_s1_col);
            r_s1_fwd_data <= {above1, r_s1_cur};
        end
    end

    // window shift and stage 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (s1_fire) begin
            r_s2_valid <= r_s1_res;
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= above2;
            r_win[1][2] <= above1;
            r_win[2][2] <= r_s1_cur;
        end else if (s2_fire) begin
            r_s2_valid <= 1'b0;
        end
        if (s1_fire) begin
            r_s2_last  <= r_s1_last;
            r_s2_rmask <= r_s1_rmask;
            r_s2_cmask <= r_s1_cmask;
        end
    end

    assign coef_rows[0] = r_coef_top;
    assign coef_rows[1] = r_coef_mid;
    assign coef_rows[2] = r_coef_bot;

    // nine masked products summed at full precision
    always_comb begin
        logic signed [imconv_pkg::PROD_W-1:0] prod;
        acc = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod = $signed(r_win[r][c]) *
                       $signed(coef_rows[r][imconv_pkg::PIX_W*c +: imconv_pkg::PIX_W]);
                if (r_s2_rmask[r] && r_s2_cmask[c]) begin
                    acc = acc + imconv_pkg::ACC_W'(prod);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (s2_fire) begin
            r_out_data <= acc[imconv_pkg::SUM_W-1:0];
            r_out_last <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out_data};
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== hdl/imconv_chk.sv =====
// port checker for the image correlation block and its bind
`include "image_conv_3x3_zero_padded_macros.svh"

module imconv_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled result word holds its value
    `IMCONV_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result word changed while stalled")

    // a free output register lets the whole pipe take a word
    `IMCONV_ASSERT_IMP(a_ready_free, i_clk, i_rst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input blocked with free output")

    // a result may not appear too soon after reset
    `IMCONV_ASSERT_RAW(a_rst_quiet, i_clk, !i_rst_n, ##3 !m_axis_tvalid, "result too soon after reset")

endmodule

bind image_conv_3x3_zero_padded imconv_chk u_imconv_chk (.*);
